### rtl/core/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion wrappers, compiled out for synthesis.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
// clocked check, disabled while reset is low
`define ASSERT_CLK(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// clocked check, also active during reset
`define ASSERT_CLK_ALWAYS(lbl, clk, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define ASSERT_CLK(lbl, clk, rst_n, prop, msg)
`define ASSERT_CLK_ALWAYS(lbl, clk, prop, msg)
`endif

`endif

### rtl/core/pal_pkg.sv
// ----------------------------------------------------------------------------
// pal_pkg
// Shared codes and controller/datapath interface types of the array list.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package pal_pkg;

	localparam logic [2:0] ACT_GET    = 3'd0;
	localparam logic [2:0] ACT_LOCATE = 3'd1;
	localparam logic [2:0] ACT_INSERT = 3'd2;
	localparam logic [2:0] ACT_REMOVE = 3'd3;
	localparam logic [2:0] ACT_PUSH   = 3'd4;
	localparam logic [2:0] ACT_POP    = 3'd5;

	// address sources
	localparam logic [1:0] SEL_ZERO = 2'd0;
	localparam logic [1:0] SEL_POS  = 2'd1;  // position - 1
	localparam logic [1:0] SEL_CNT  = 2'd2;  // count - 1 (count for writes)

	typedef struct packed {
		logic       load;
		logic       idx_init;
		logic [1:0] idx_sel;
		logic [1:0] end_sel;
		logic       rd;
		logic       step;
		logic       down;
		logic       shift_up;
		logic       shift_dn;
		logic       wr_val;
		logic [1:0] wa_sel;
		logic       cap_elem;
		logic       cap_found;
		logic       set_ok;
		logic       cnt_inc;
		logic       cnt_dec;
		logic       out_load;
	} cmd_t;

	typedef struct packed {
		logic pos_ok_rd;
		logic pos_ok_ins;
		logic ins_at_end;
		logic full;
		logic empty;
		logic idx_last;
		logic s1_first;
		logic hit;
	} sts_t;

endpackage

### rtl/core/pal_ctrl.sv
// ----------------------------------------------------------------------------
// pal_ctrl
// Sequencer: decodes the action, walks the store and hands off the result.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "assert_macros.svh"

module pal_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	output logic           in_ready,
	input  logic [2:0]     action,
	output logic           out_valid,
	input  logic           out_ready,
	output pal_pkg::cmd_t  cmd,
	input  pal_pkg::sts_t  sts
);

	localparam logic [2:0] S_IDLE   = 3'd0;
	localparam logic [2:0] S_DECIDE = 3'd1;
	localparam logic [2:0] S_WALK   = 3'd2;
	localparam logic [2:0] S_DRAIN  = 3'd3;
	localparam logic [2:0] S_PUT    = 3'd4;
	localparam logic [2:0] S_FIN    = 3'd5;

	logic [2:0] state_q;
	logic [2:0] state_nxt;
	logic [2:0] op_q;
	logic       rvld_q;
	logic       out_valid_q;
	logic       hit_stop;

	assign in_ready  = (state_q == S_IDLE);
	assign out_valid = out_valid_q;

	always_comb begin
		cmd       = '0;
		state_nxt = state_q;
		hit_stop  = 1'b0;
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.load  = 1'b1;
					state_nxt = S_DECIDE;
				end
			end
			S_DECIDE: begin
				state_nxt = S_FIN;
				case (op_q)
					pal_pkg::ACT_GET: begin
						if (sts.pos_ok_rd) begin
							cmd.idx_init = 1'b1;
							cmd.idx_sel  = pal_pkg::SEL_POS;
							cmd.end_sel  = pal_pkg::SEL_POS;
							cmd.set_ok   = 1'b1;
							state_nxt    = S_WALK;
						end
					end
					pal_pkg::ACT_LOCATE: begin
						if (!sts.empty) begin
							cmd.idx_init = 1'b1;
							cmd.idx_sel  = pal_pkg::SEL_ZERO;
							cmd.end_sel  = pal_pkg::SEL_CNT;
							state_nxt    = S_WALK;
						end
					end
					pal_pkg::ACT_INSERT: begin
						if (sts.pos_ok_ins) begin
							cmd.set_ok  = 1'b1;
							cmd.cnt_inc = 1'b1;
							if (sts.ins_at_end) begin
								cmd.wr_val = 1'b1;
								cmd.wa_sel = pal_pkg::SEL_POS;
							end else begin
								cmd.idx_init = 1'b1;
								cmd.idx_sel  = pal_pkg::SEL_CNT;
								cmd.end_sel  = pal_pkg::SEL_POS;
								state_nxt    = S_WALK;
							end
						end
					end
					pal_pkg::ACT_REMOVE: begin
						if (sts.pos_ok_rd) begin
							cmd.set_ok   = 1'b1;
							cmd.cnt_dec  = 1'b1;
							cmd.idx_init = 1'b1;
							cmd.idx_sel  = pal_pkg::SEL_POS;
							cmd.end_sel  = pal_pkg::SEL_CNT;
							state_nxt    = S_WALK;
						end
					end
					pal_pkg::ACT_PUSH: begin
						if (!sts.full) begin
							cmd.wr_val  = 1'b1;
							cmd.wa_sel  = pal_pkg::SEL_CNT;
							cmd.cnt_inc = 1'b1;
							cmd.set_ok  = 1'b1;
						end
					end
					pal_pkg::ACT_POP: begin
						if (!sts.empty) begin
							cmd.idx_init = 1'b1;
							cmd.idx_sel  = pal_pkg::SEL_CNT;
							cmd.end_sel  = pal_pkg::SEL_CNT;
							cmd.cnt_dec  = 1'b1;
							cmd.set_ok   = 1'b1;
							state_nxt    = S_WALK;
						end
					end
					default: begin
					end
				endcase
			end
			S_WALK, S_DRAIN: begin
				// handle the entry read in the previous cycle
				if (rvld_q) begin
					case (op_q)
						pal_pkg::ACT_GET, pal_pkg::ACT_POP: cmd.cap_elem = 1'b1;
						pal_pkg::ACT_REMOVE: begin
							if (sts.s1_first) begin
								cmd.cap_elem = 1'b1;
							end else begin
								cmd.shift_dn = 1'b1;
							end
						end
						pal_pkg::ACT_INSERT: cmd.shift_up = 1'b1;
						pal_pkg::ACT_LOCATE: begin
							if (sts.hit) begin
								cmd.cap_found = 1'b1;
								cmd.set_ok    = 1'b1;
								hit_stop      = 1'b1;
							end
						end
						default: begin
						end
					endcase
				end
				if (hit_stop) begin
					state_nxt = S_FIN;
				end else if (state_q == S_WALK) begin
					cmd.rd   = 1'b1;
					cmd.down = (op_q == pal_pkg::ACT_INSERT);
					if (sts.idx_last) begin
						state_nxt = S_DRAIN;
					end else begin
						cmd.step = 1'b1;
					end
				end else begin
					state_nxt = (op_q == pal_pkg::ACT_INSERT) ? S_PUT : S_FIN;
				end
			end
			S_PUT: begin
				cmd.wr_val = 1'b1;
				cmd.wa_sel = pal_pkg::SEL_POS;
				state_nxt  = S_FIN;
			end
			S_FIN: begin
				if (!out_valid_q || out_ready) begin
					cmd.out_load = 1'b1;
					state_nxt    = S_IDLE;
				end
			end
			default: state_nxt = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			op_q        <= pal_pkg::ACT_GET;
			rvld_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_nxt;
			rvld_q  <= cmd.rd;
			if (cmd.load) begin
				op_q <= action;
			end
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	`ASSERT_CLK(a_shift_has_data, clk, arst_n, (cmd.shift_up || cmd.shift_dn) |-> rvld_q, "shift without read data")
	`ASSERT_CLK(a_out_hold, clk, arst_n, (out_valid_q && !out_ready) |-> !cmd.out_load, "result overwritten while stalled")
	`ASSERT_CLK_ALWAYS(a_idle_no_out_load, clk, (state_q == S_IDLE) |-> !cmd.out_load, "result loaded from idle")

endmodule

### rtl/core/pal_dp.sv
// ----------------------------------------------------------------------------
// pal_dp
// Datapath: entry store, count, walk index, result and output registers.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "assert_macros.svh"

module pal_dp #(
	parameter int DEPTH      = 64,
	parameter int ELEM_WIDTH = 32
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic [6:0]     position,
	input  logic [31:0]    value,
	input  pal_pkg::cmd_t  cmd,
	output pal_pkg::sts_t  sts,
	output logic           ok,
	output logic [31:0]    elem_out,
	output logic [6:0]     found_at,
	output logic [6:0]     count_now,
	output logic           is_empty
);

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);
	localparam int XW = ((CW > 7) ? CW : 7) + 1;

	logic [ELEM_WIDTH-1:0] mem_q [DEPTH];
	logic [ELEM_WIDTH-1:0] rdata_s1;
	logic [AW-1:0]         raddr_s1;

	logic [CW-1:0]         cnt_q;
	logic [6:0]            pos_q;
	logic [ELEM_WIDTH-1:0] val_q;
	logic [AW-1:0]         idx_q;
	logic [AW-1:0]         end_q;

	logic                  ok_q;
	logic [31:0]           elem_q;
	logic [6:0]            found_q;

	logic                  ok_out_q;
	logic [31:0]           elem_out_q;
	logic [6:0]            found_out_q;
	logic [6:0]            count_out_q;
	logic                  empty_out_q;

	logic [XW-1:0]         pos_x;
	logic [XW-1:0]         cnt_x;
	logic [AW-1:0]         pos_m1;
	logic [AW-1:0]         cnt_m1;
	logic [AW-1:0]         idx_src;
	logic [AW-1:0]         end_src;
	logic                  wr_en;
	logic [AW-1:0]         wr_addr;
	logic [ELEM_WIDTH-1:0] wr_data;

	assign pos_x  = XW'(pos_q);
	assign cnt_x  = XW'(cnt_q);
	assign pos_m1 = AW'(pos_x - XW'(1));
	assign cnt_m1 = AW'(cnt_q - CW'(1));

	assign sts.full       = (cnt_q == CW'(DEPTH));
	assign sts.empty      = (cnt_q == '0);
	assign sts.pos_ok_rd  = (pos_q != '0) && (pos_x <= cnt_x);
	assign sts.ins_at_end = (pos_x == cnt_x + XW'(1));
	assign sts.pos_ok_ins = (pos_q != '0) && (pos_x <= cnt_x + XW'(1)) && !sts.full;
	assign sts.idx_last   = (idx_q == end_q);
	assign sts.s1_first   = (raddr_s1 == pos_m1);
	assign sts.hit        = (rdata_s1 == val_q);

	always_comb begin
		case (cmd.idx_sel)
			pal_pkg::SEL_POS: idx_src = pos_m1;
			pal_pkg::SEL_CNT: idx_src = cnt_m1;
			default:          idx_src = '0;
		endcase
		case (cmd.end_sel)
			pal_pkg::SEL_POS: end_src = pos_m1;
			pal_pkg::SEL_CNT: end_src = cnt_m1;
			default:          end_src = '0;
		endcase
	end

	always_comb begin
		wr_en   = cmd.shift_up || cmd.shift_dn || cmd.wr_val;
		wr_data = rdata_s1;
		if (cmd.shift_up) begin
			wr_addr = raddr_s1 + AW'(1);
		end else if (cmd.shift_dn) begin
			wr_addr = raddr_s1 - AW'(1);
		end else begin
			wr_data = val_q;
			wr_addr = (cmd.wa_sel == pal_pkg::SEL_CNT) ? AW'(cnt_q) : pos_m1;
		end
	end

	// entry store: one write and one registered read per cycle
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (cmd.rd) begin
			rdata_s1 <= mem_q[idx_q];
			raddr_s1 <= idx_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (cmd.cnt_inc) begin
			cnt_q <= cnt_q + CW'(1);
		end else if (cmd.cnt_dec) begin
			cnt_q <= cnt_q - CW'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			pos_q   <= position;
			val_q   <= ELEM_WIDTH'(value);
			ok_q    <= 1'b0;
			elem_q  <= '0;
			found_q <= '0;
		end else begin
			if (cmd.set_ok) begin
				ok_q <= 1'b1;
			end
			if (cmd.cap_elem) begin
				elem_q <= 32'(rdata_s1);
			end
			if (cmd.cap_found) begin
				found_q <= 7'(CW'(raddr_s1) + CW'(1));
			end
		end
		if (cmd.idx_init) begin
			idx_q <= idx_src;
			end_q <= end_src;
		end else if (cmd.step) begin
			idx_q <= cmd.down ? idx_q - AW'(1) : idx_q + AW'(1);
		end
		if (cmd.out_load) begin
			ok_out_q    <= ok_q;
			elem_out_q  <= elem_q;
			found_out_q <= found_q;
			count_out_q <= 7'(cnt_q);
			empty_out_q <= (cnt_q == '0);
		end
	end

	assign ok        = ok_out_q;
	assign elem_out  = elem_out_q;
	assign found_at  = found_out_q;
	assign count_now = count_out_q;
	assign is_empty  = empty_out_q;

	`ASSERT_CLK(a_no_overflow, clk, arst_n, cmd.cnt_inc |-> !sts.full, "count overflow")
	`ASSERT_CLK(a_no_underflow, clk, arst_n, cmd.cnt_dec |-> !sts.empty, "count underflow")
	`ASSERT_CLK(a_one_writer, clk, arst_n, !(cmd.wr_val && (cmd.shift_up || cmd.shift_dn)), "store write conflict")

endmodule

### rtl/core/positional_array_list.sv
// ----------------------------------------------------------------------------
// positional_array_list
// Fixed-capacity ordered list with get, locate, insert, remove, push and pop.
// ----------------------------------------------------------------------------
// One item is handled at a time; the store has one write and one registered
// read port, so every walk moves one entry per cycle. The result sits in an
// output register, and a new item is taken as soon as the previous one has
// been handed to that register. Store contents need no clearing after reset:
// only entries below the count are ever read.
`timescale 1ns / 1ps

module positional_array_list #(
	parameter int DEPTH      = 64,
	parameter int ELEM_WIDTH = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [2:0]  action,
	input  logic [6:0]  position,
	input  logic [31:0] value,
	output logic        out_valid,
	input  logic        out_ready,
	output logic        ok,
	output logic [31:0] elem_out,
	output logic [6:0]  found_at,
	output logic [6:0]  count_now,
	output logic        is_empty
);

	pal_pkg::cmd_t cmd;
	pal_pkg::sts_t sts;

	pal_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.action    (action),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.cmd       (cmd),
		.sts       (sts)
	);

	pal_dp #(
		.DEPTH      (DEPTH),
		.ELEM_WIDTH (ELEM_WIDTH)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.position  (position),
		.value     (value),
		.cmd       (cmd),
		.sts       (sts),
		.ok        (ok),
		.elem_out  (elem_out),
		.found_at  (found_at),
		.count_now (count_now),
		.is_empty  (is_empty)
	);

endmodule
